[design/i2cbm_pkg.sv]
// i2cbm_pkg: types, codes and timing constants of the i2c bit-bang master sequencer
// used by every module of the block; depends on nothing
package i2cbm_pkg;

  localparam logic [2:0] REQ_CODE_TICK  = 3'd0;
  localparam logic [2:0] REQ_CODE_START = 3'd1;
  localparam logic [2:0] REQ_CODE_STOP  = 3'd2;
  localparam logic [2:0] REQ_CODE_WRITE = 3'd3;
  localparam logic [2:0] REQ_CODE_READ  = 3'd4;
  localparam logic [2:0] REQ_CODE_WACK  = 3'd5;

  localparam logic       CFG_TPM      = 1'b0;
  localparam logic       CFG_TIMEOUT  = 1'b1;
  localparam logic [7:0] TPM_RESET    = 8'd1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd250;

  localparam logic [2:0] START_A_US = 3'd5;
  localparam logic [2:0] START_B_US = 3'd6;
  localparam logic [2:0] STOP_US    = 3'd6;
  localparam logic [2:0] BIT_US     = 3'd2;
  localparam logic [2:0] RHIGH_US   = 3'd1;
  localparam logic [2:0] AHIGH_US   = 3'd5;
  localparam logic [2:0] KREL_US    = 3'd1;
  localparam logic [2:0] POLL_US    = 3'd0;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    REQ_TICK,
    REQ_START,
    REQ_STOP,
    REQ_WRITE,
    REQ_READ,
    REQ_WACK,
    REQ_NONE
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_A,
    ST_START_B,
    ST_STOP_A,
    ST_STOP_B,
    ST_W_SETUP,
    ST_W_HIGH,
    ST_W_LOW,
    ST_R_LOW,
    ST_R_HIGH,
    ST_A_SETUP,
    ST_A_HIGH,
    ST_K_REL,
    ST_K_HIGH,
    ST_K_POLL
  } step_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    req_e       kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } res_t;

endpackage

[design/i2c_bitbang_master_sequencer_unit.sv]
// i2c_bitbang_master_sequencer_unit: top level of the i2c bit-bang master sequencer
// depends on i2cbm_pkg, i2cbm_front, i2cbm_engine and i2cbm_outq
//
//   port group   dir   handshake                 beat
//   request      in    push / full               i2cbm_pkg::in_item_t
//   result       out   empty / pop               i2cbm_pkg::res_t
//   config       in    cfg_we_i, cfg_idx_i       cfg_wdata_i, 8 bits
//
// one request beat is taken per cycle while the request queue is not full
// a request passes the request queue, then the sequencer step, into the result queue
// reset leaves the bus released (scl, sda high, sda driven) and both queues empty
// a stalled result side fills the two-entry result queue, then the request queue
module i2c_bitbang_master_sequencer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  i2cbm_pkg::in_item_t in_item_i,
  output logic                empty,
  input  logic                pop,
  output i2cbm_pkg::res_t     out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);

  logic            cmd_valid;
  logic            cmd_take;
  i2cbm_pkg::cmd_t cmd;
  logic            res_full;
  logic            res_push;
  i2cbm_pkg::res_t res;

  i2cbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  i2cbm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  i2cbm_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

[design/i2cbm_front.sv]
// i2cbm_front: accepts request beats, classifies the request code and
// holds classified commands in a two-entry queue; depends on i2cbm_pkg
module i2cbm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  i2cbm_pkg::in_item_t in_item_i,
  output logic                cmd_valid_o,
  output i2cbm_pkg::cmd_t     cmd_o,
  input  logic                cmd_take_i
);

  i2cbm_pkg::cmd_t  slot_q [2];
  i2cbm_pkg::cmd_t  cls;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_en;

  always_comb begin
    cls.data_byte  = in_item_i.data_byte;
    cls.send_ack   = in_item_i.send_ack;
    cls.sda_sample = in_item_i.sda_sample;
    case (in_item_i.req_type)
      i2cbm_pkg::REQ_CODE_TICK:  cls.kind = i2cbm_pkg::REQ_TICK;
      i2cbm_pkg::REQ_CODE_START: cls.kind = i2cbm_pkg::REQ_START;
      i2cbm_pkg::REQ_CODE_STOP:  cls.kind = i2cbm_pkg::REQ_STOP;
      i2cbm_pkg::REQ_CODE_WRITE: cls.kind = i2cbm_pkg::REQ_WRITE;
      i2cbm_pkg::REQ_CODE_READ:  cls.kind = i2cbm_pkg::REQ_READ;
      i2cbm_pkg::REQ_CODE_WACK:  cls.kind = i2cbm_pkg::REQ_WACK;
      default:                   cls.kind = i2cbm_pkg::REQ_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign wr_en       = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ cmd_take_i;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, cmd_take_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[design/i2cbm_engine.sv]
// i2cbm_engine: config registers; the bus sequencer carries out one classified
// command per cycle, unless res_full_i, and forms its result; uses i2cbm_pkg
module i2cbm_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             cmd_valid_i,
  input  i2cbm_pkg::cmd_t  cmd_i,
  output logic             cmd_take_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output i2cbm_pkg::res_t  res_o
);

  logic [7:0]          tpm_q, timeout_q;
  i2cbm_pkg::step_e    step_q, step_d;
  logic [10:0]         delay_q, delay_d;
  logic [3:0]          bit_idx_q, bit_idx_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          poll_q, poll_d;
  logic                ack_choice_q, ack_choice_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                dir_q, dir_d;
  logic                ack_fail_q, ack_fail_d;
  logic [7:0]          hold_q, hold_d;
  logic                done;
  logic                load;
  logic [2:0]          ph_us;
  logic [7:0]          tpm_eff;
  logic [3:0]          bit_inc;
  logic [7:0]          shift_in;
  logic                take;

  assign take       = cmd_valid_i && !res_full_i;
  assign cmd_take_o = take;
  assign res_push_o = take;
  assign tpm_eff    = (tpm_q == 8'd0) ? 8'd1 : tpm_q;
  assign bit_inc    = bit_idx_q + 4'd1;
  assign shift_in   = {shift_q[6:0], cmd_i.sda_sample};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q     <= i2cbm_pkg::TPM_RESET;
      timeout_q <= i2cbm_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cbm_pkg::CFG_TPM:     tpm_q     <= cfg_wdata_i;
        i2cbm_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default:                tpm_q     <= tpm_q;
      endcase
    end
  end

  // next state
  always_comb begin
    step_d       = step_q;
    delay_d      = delay_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    poll_d       = poll_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    dir_d        = dir_q;
    ack_fail_d   = ack_fail_q;
    hold_d       = hold_q;
    done         = 1'b0;
    load         = 1'b0;
    ph_us        = i2cbm_pkg::POLL_US;
    if (take) begin
      if (step_q != i2cbm_pkg::ST_IDLE) begin
        if (cmd_i.kind == i2cbm_pkg::REQ_TICK) begin
          if (step_q == i2cbm_pkg::ST_K_POLL) begin
            if (!cmd_i.sda_sample) begin
              scl_d      = 1'b0;
              ack_fail_d = 1'b0;
              step_d     = i2cbm_pkg::ST_IDLE;
              done       = 1'b1;
            end else if (poll_q >= timeout_q) begin
              ack_fail_d = 1'b1;
              dir_d      = 1'b1;
              scl_d      = 1'b1;
              sda_d      = 1'b0;
              step_d     = i2cbm_pkg::ST_STOP_A;
              load       = 1'b1;
              ph_us      = i2cbm_pkg::STOP_US;
            end else begin
              poll_d = poll_q + 8'd1;
            end
          end else if (delay_q > 11'd1) begin
            delay_d = delay_q - 11'd1;
          end else begin
            case (step_q)
              i2cbm_pkg::ST_START_A: begin
                sda_d  = 1'b0;
                step_d = i2cbm_pkg::ST_START_B;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::START_B_US;
              end
              i2cbm_pkg::ST_START_B: begin
                scl_d = 1'b0;
                done  = 1'b1;
              end
              i2cbm_pkg::ST_STOP_A: begin
                sda_d  = 1'b1;
                step_d = i2cbm_pkg::ST_STOP_B;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::STOP_US;
              end
              i2cbm_pkg::ST_W_SETUP: begin
                scl_d  = 1'b1;
                step_d = i2cbm_pkg::ST_W_HIGH;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::BIT_US;
              end
              i2cbm_pkg::ST_W_HIGH: begin
                scl_d  = 1'b0;
                step_d = i2cbm_pkg::ST_W_LOW;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::BIT_US;
              end
              i2cbm_pkg::ST_W_LOW: begin
                bit_idx_d = bit_inc;
                if (bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                  done = 1'b1;
                end else begin
                  sda_d  = shift_q[~bit_inc[2:0]];
                  step_d = i2cbm_pkg::ST_W_SETUP;
                  load   = 1'b1;
                  ph_us  = i2cbm_pkg::BIT_US;
                end
              end
              i2cbm_pkg::ST_R_LOW: begin
                scl_d  = 1'b1;
                step_d = i2cbm_pkg::ST_R_HIGH;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::RHIGH_US;
              end
              i2cbm_pkg::ST_R_HIGH: begin
                shift_d   = shift_in;
                bit_idx_d = bit_inc;
                scl_d     = 1'b0;
                load      = 1'b1;
                ph_us     = i2cbm_pkg::BIT_US;
                if (bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                  hold_d = shift_in;
                  dir_d  = 1'b1;
                  sda_d  = !ack_choice_q;
                  step_d = i2cbm_pkg::ST_A_SETUP;
                end else begin
                  step_d = i2cbm_pkg::ST_R_LOW;
                end
              end
              i2cbm_pkg::ST_A_SETUP: begin
                scl_d  = 1'b1;
                step_d = i2cbm_pkg::ST_A_HIGH;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::AHIGH_US;
              end
              i2cbm_pkg::ST_A_HIGH: begin
                scl_d = 1'b0;
                done  = 1'b1;
              end
              i2cbm_pkg::ST_K_REL: begin
                dir_d  = 1'b0;
                scl_d  = 1'b1;
                step_d = i2cbm_pkg::ST_K_HIGH;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::RHIGH_US;
              end
              i2cbm_pkg::ST_K_HIGH: begin
                step_d = i2cbm_pkg::ST_K_POLL;
                load   = 1'b1;
                ph_us  = i2cbm_pkg::POLL_US;
              end
              default: begin
                done = 1'b1;
              end
            endcase
            if (done) begin
              step_d  = i2cbm_pkg::ST_IDLE;
              delay_d = 11'd0;
            end
          end
        end
      end else begin
        case (cmd_i.kind)
          i2cbm_pkg::REQ_START: begin
            dir_d  = 1'b1;
            sda_d  = 1'b1;
            scl_d  = 1'b1;
            step_d = i2cbm_pkg::ST_START_A;
            load   = 1'b1;
            ph_us  = i2cbm_pkg::START_A_US;
          end
          i2cbm_pkg::REQ_STOP: begin
            dir_d  = 1'b1;
            scl_d  = 1'b1;
            sda_d  = 1'b0;
            step_d = i2cbm_pkg::ST_STOP_A;
            load   = 1'b1;
            ph_us  = i2cbm_pkg::STOP_US;
          end
          i2cbm_pkg::REQ_WRITE: begin
            shift_d   = cmd_i.data_byte;
            bit_idx_d = 4'd0;
            dir_d     = 1'b1;
            scl_d     = 1'b0;
            sda_d     = cmd_i.data_byte[7];
            step_d    = i2cbm_pkg::ST_W_SETUP;
            load      = 1'b1;
            ph_us     = i2cbm_pkg::BIT_US;
          end
          i2cbm_pkg::REQ_READ: begin
            ack_choice_d = cmd_i.send_ack;
            shift_d      = 8'd0;
            bit_idx_d    = 4'd0;
            dir_d        = 1'b0;
            scl_d        = 1'b0;
            step_d       = i2cbm_pkg::ST_R_LOW;
            load         = 1'b1;
            ph_us        = i2cbm_pkg::BIT_US;
          end
          i2cbm_pkg::REQ_WACK: begin
            poll_d = 8'd0;
            sda_d  = 1'b1;
            step_d = i2cbm_pkg::ST_K_REL;
            load   = 1'b1;
            ph_us  = i2cbm_pkg::KREL_US;
          end
          default: begin
            step_d = step_q;
          end
        endcase
      end
      if (load) begin
        delay_d = 11'(ph_us) * 11'(tpm_eff);
      end
    end
  end

  // result beat
  always_comb begin
    res_o.scl_level  = scl_d;
    res_o.sda_level  = sda_d;
    res_o.sda_drive  = dir_d;
    res_o.busy_res   = (step_d != i2cbm_pkg::ST_IDLE);
    res_o.done_res   = done;
    res_o.read_data  = hold_d;
    res_o.ack_failed = ack_fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= i2cbm_pkg::ST_IDLE;
      delay_q      <= 11'd0;
      bit_idx_q    <= 4'd0;
      shift_q      <= 8'd0;
      poll_q       <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      dir_q        <= 1'b1;
      ack_fail_q   <= 1'b0;
      hold_q       <= 8'd0;
    end else begin
      step_q       <= step_d;
      delay_q      <= delay_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      poll_q       <= poll_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      dir_q        <= dir_d;
      ack_fail_q   <= ack_fail_d;
      hold_q       <= hold_d;
    end
  end

endmodule

[design/i2cbm_outq.sv]
// i2cbm_outq: two-entry result queue between the sequencer and the result port
// depends on i2cbm_pkg
module i2cbm_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_push_i,
  input  i2cbm_pkg::res_t  res_i,
  output logic             res_full_o,
  output logic             empty,
  input  logic             pop,
  output i2cbm_pkg::res_t  out_item_o
);

  i2cbm_pkg::res_t  slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign rd_en      = pop && !empty;
  assign out_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ res_push_i;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + {1'b0, res_push_i} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
